// ===== hdl/trace_ring_page_parser_assert.svh =====
// Assertion macros for the trace page parser
`ifndef TRACE_RING_PAGE_PARSER_ASSERT_SVH
`define TRACE_RING_PAGE_PARSER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define TRP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// next-cycle implication
`define TRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`endif

// ===== hdl/trp_pkg.sv =====
// ----------------------------------------------------------------------------
// trp_pkg
// Types and constants shared by the trace page parser.
// ----------------------------------------------------------------------------
package trp_pkg;

    localparam int unsigned NUM_REGS    = 4;
    localparam int unsigned REG_W       = 16;
    localparam int unsigned REG_IDX_W   = 2;

    localparam logic [1:0] REG_ENTRY    = 2'd0;
    localparam logic [1:0] REG_EXIT     = 2'd1;
    localparam logic [1:0] REG_SWITCH   = 2'd2;
    localparam logic [1:0] REG_WAKEUP   = 2'd3;

    localparam logic [2:0] CLASS_ENTRY  = 3'd0;
    localparam logic [2:0] CLASS_EXIT   = 3'd1;
    localparam logic [2:0] CLASS_SWITCH = 3'd2;
    localparam logic [2:0] CLASS_WAKEUP = 3'd3;
    localparam logic [2:0] CLASS_NONE   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_TYPE  = 2'd1;
    localparam logic [1:0] ST_BAD_ID    = 2'd2;
    localparam logic [1:0] ST_OVERRUN   = 2'd3;

    localparam logic [4:0] TYPE_LEN0    = 5'd0;
    localparam logic [4:0] TYPE_MAXDATA = 5'd28;
    localparam logic [4:0] TYPE_PAD     = 5'd29;
    localparam logic [4:0] TYPE_EXT     = 5'd30;
    localparam int unsigned DELTA_SHIFT = 27;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  event_class;
        logic [63:0] event_time;
        logic [9:0]  cpu_tag;
        logic [9:0]  word_offset;
        logic        first_word;
        logic        last_word;
        logic [1:0]  status;
    } result_t;

    // page word with its start flag and cpu number, handed from front to back
    typedef struct packed {
        logic [31:0] word;
        logic        start;
        logic [9:0]  cpu;
    } item_t;

endpackage

// ===== hdl/trp_if.sv =====
// ----------------------------------------------------------------------------
// trp_in_if / trp_out_if
// Valid/ready channels for page words and results.
// ----------------------------------------------------------------------------
interface trp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] page_word;
    logic        page_start;
    logic [9:0]  cpu_number;
    modport source (output valid, page_word, page_start, cpu_number, input ready);
    modport sink   (input valid, page_word, page_start, cpu_number, output ready);
endinterface

interface trp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  event_class;
    logic [63:0] event_time;
    logic [9:0]  cpu_tag;
    logic [9:0]  word_offset;
    logic        first_word;
    logic        last_word;
    logic [1:0]  status;
    modport source (output valid, data_word, event_class, event_time, cpu_tag,
                    word_offset, first_word, last_word, status, input ready);
    modport sink   (input valid, data_word, event_class, event_time, cpu_tag,
                    word_offset, first_word, last_word, status, output ready);
endinterface

// ===== hdl/trp_queue.sv =====
// ----------------------------------------------------------------------------
// trp_queue
// Short word queue between the front and the parser core.
// ----------------------------------------------------------------------------
module trp_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  trp_pkg::item_t    in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output trp_pkg::item_t    out_item
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    trp_pkg::item_t   mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg, rptr_reg;
    logic [AW:0]      count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg != (AW+1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == AW'(DEPTH-1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == AW'(DEPTH-1)) ? '0 : rptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

// ===== hdl/trp_core.sv =====
// ----------------------------------------------------------------------------
// trp_core
// Parses one page word per cycle while the result stage is not stalled, and drives a registered result stage.
// ----------------------------------------------------------------------------
module trp_core #(
    parameter int unsigned PAGE_BYTES = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  trp_pkg::item_t             in_item,
    input  logic [trp_pkg::REG_W-1:0]  id_entry,
    input  logic [trp_pkg::REG_W-1:0]  id_exit,
    input  logic [trp_pkg::REG_W-1:0]  id_switch,
    input  logic [trp_pkg::REG_W-1:0]  id_wakeup,
    output logic                       res_valid,
    input  logic                       res_ready,
    output trp_pkg::result_t           res
);
    localparam int unsigned RW = $clog2(PAGE_BYTES + 1);
    localparam logic [31:0] LIMIT = 32'(PAGE_BYTES - 16);

    typedef enum logic [3:0] {
        PH_WAIT, PH_TS_HI, PH_LEN_LO, PH_LEN_HI, PH_HDR, PH_LEN0,
        PH_PAD_LEN, PH_PAD_SKIP, PH_EXT, PH_PAYLOAD, PH_DONE, PH_DISCARD
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [63:0]       time_reg, time_next;
    logic [31:0]       len_lo_reg, len_lo_next;
    logic [RW-1:0]     left_reg, left_next;
    logic [10:0]       items_reg, items_next;
    logic [26:0]       delta_reg, delta_next;
    logic [2:0]        class_reg, class_next;
    logic [9:0]        index_reg, index_next;
    logic [9:0]        cpu_reg, cpu_next;
    logic              res_valid_reg;
    trp_pkg::result_t  res_reg;

    logic              emit;
    trp_pkg::result_t  emit_res;
    logic              take;
    logic [31:0]       w;
    logic [RW-1:0]     left_dec;
    logic [31:0]       body_bytes;
    logic [30:0]       body_wds;
    logic              body_bad;
    logic [4:0]        ttype;
    logic [2:0]        id_class;
    logic [63:0]       ext_add;

    assign in_ready  = !res_valid_reg || res_ready;
    assign take      = in_valid && in_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign w         = in_item.word;
    assign ttype     = w[4:0];
    assign left_dec  = left_reg - RW'(4);
    assign body_bytes = w - 32'd4;
    assign body_wds  = 31'((33'(body_bytes) + 33'd3) >> 2);
    assign body_bad  = (w < 32'd4) ||
                       ({body_wds, 2'b00} > 33'(left_dec));
    assign ext_add   = {5'd0, w, 27'd0} + 64'(delta_reg);

    always_comb
    begin
        if (w[15:0] == id_entry)       id_class = trp_pkg::CLASS_ENTRY;
        else if (w[15:0] == id_exit)   id_class = trp_pkg::CLASS_EXIT;
        else if (w[15:0] == id_switch) id_class = trp_pkg::CLASS_SWITCH;
        else if (w[15:0] == id_wakeup) id_class = trp_pkg::CLASS_WAKEUP;
        else                           id_class = trp_pkg::CLASS_NONE;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        time_next   = time_reg;
        len_lo_next = len_lo_reg;
        left_next   = left_reg;
        items_next  = items_reg;
        delta_next  = delta_reg;
        class_next  = class_reg;
        index_next  = index_reg;
        cpu_next    = cpu_reg;
        emit        = 1'b0;
        emit_res.data_word   = w;
        emit_res.event_class = trp_pkg::CLASS_NONE;
        emit_res.event_time  = time_reg;
        emit_res.cpu_tag     = cpu_reg;
        emit_res.word_offset = '0;
        emit_res.first_word  = 1'b0;
        emit_res.last_word   = 1'b0;
        emit_res.status      = trp_pkg::ST_OK;

        if (in_item.start)
        begin
            cpu_next   = in_item.cpu;
            time_next  = {32'd0, w};
            left_next  = '0;
            items_next = '0;
            delta_next = '0;
            index_next = '0;
            class_next = trp_pkg::CLASS_NONE;
            phase_next = PH_TS_HI;
        end
        else
        begin
            unique case (phase_reg)
                PH_TS_HI:
                begin
                    time_next  = {w, time_reg[31:0]};
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_lo_next = w;
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    if (w != 32'd0 || len_lo_reg > LIMIT)
                    begin
                        left_next       = '0;
                        emit            = 1'b1;
                        emit_res.status = trp_pkg::ST_OVERRUN;
                        phase_next      = PH_DISCARD;
                    end
                    else
                    begin
                        left_next  = RW'(len_lo_reg);
                        phase_next = (len_lo_reg == 32'd0) ? PH_DONE : PH_HDR;
                    end
                end
                PH_HDR, PH_LEN0, PH_PAD_LEN, PH_PAD_SKIP, PH_EXT, PH_PAYLOAD:
                begin
                    if (left_reg < RW'(4))
                    begin
                        emit            = 1'b1;
                        emit_res.status = trp_pkg::ST_OVERRUN;
                        phase_next      = PH_DISCARD;
                    end
                    else
                    begin
                        left_next = left_dec;
                        unique case (phase_reg)
                            PH_HDR:
                            begin
                                if (ttype == trp_pkg::TYPE_LEN0)
                                begin
                                    delta_next = w[31:5];
                                    phase_next = PH_LEN0;
                                end
                                else if (ttype <= trp_pkg::TYPE_MAXDATA)
                                begin
                                    if ({ttype, 2'b00} > 7'(left_dec) ||
                                        left_dec > RW'(127))
                                    begin
                                        if ({ttype, 2'b00} > 7'(left_dec) &&
                                            left_dec <= RW'(127))
                                        begin
                                            emit            = 1'b1;
                                            emit_res.status = trp_pkg::ST_OVERRUN;
                                            phase_next      = PH_DISCARD;
                                        end
                                        else
                                        begin
                                            time_next  = time_reg + 64'(w[31:5]);
                                            items_next = 11'(ttype);
                                            index_next = '0;
                                            phase_next = PH_PAYLOAD;
                                        end
                                    end
                                    else
                                    begin
                                        time_next  = time_reg + 64'(w[31:5]);
                                        items_next = 11'(ttype);
                                        index_next = '0;
                                        phase_next = PH_PAYLOAD;
                                    end
                                end
                                else if (ttype == trp_pkg::TYPE_PAD)
                                begin
                                    if (w[31:5] == 27'd0)
                                    begin
                                        phase_next = PH_DONE;
                                    end
                                    else
                                    begin
                                        delta_next = w[31:5];
                                        phase_next = PH_PAD_LEN;
                                    end
                                end
                                else if (ttype == trp_pkg::TYPE_EXT)
                                begin
                                    delta_next = w[31:5];
                                    phase_next = PH_EXT;
                                end
                                else
                                begin
                                    emit            = 1'b1;
                                    emit_res.status = trp_pkg::ST_BAD_TYPE;
                                    phase_next      = PH_DISCARD;
                                end
                            end
                            PH_LEN0, PH_PAD_LEN:
                            begin
                                if (body_bad)
                                begin
                                    emit            = 1'b1;
                                    emit_res.status = trp_pkg::ST_OVERRUN;
                                    phase_next      = PH_DISCARD;
                                end
                                else
                                begin
                                    time_next  = time_reg + 64'(delta_reg);
                                    items_next = 11'(body_wds);
                                    if (phase_reg == PH_LEN0)
                                    begin
                                        index_next = '0;
                                    end
                                    if (body_wds == 31'd0)
                                    begin
                                        phase_next = (left_dec == '0) ? PH_DONE : PH_HDR;
                                    end
                                    else
                                    begin
                                        phase_next = (phase_reg == PH_LEN0) ?
                                                     PH_PAYLOAD : PH_PAD_SKIP;
                                    end
                                end
                            end
                            PH_PAD_SKIP:
                            begin
                                items_next = items_reg - 11'd1;
                                if (items_reg == 11'd1)
                                begin
                                    phase_next = (left_dec == '0) ? PH_DONE : PH_HDR;
                                end
                            end
                            PH_EXT:
                            begin
                                time_next  = time_reg + ext_add;
                                phase_next = (left_dec == '0) ? PH_DONE : PH_HDR;
                            end
                            default:
                            begin
                                if (index_reg == '0 && id_class == trp_pkg::CLASS_NONE)
                                begin
                                    emit            = 1'b1;
                                    emit_res.status = trp_pkg::ST_BAD_ID;
                                    phase_next      = PH_DISCARD;
                                end
                                else
                                begin
                                    if (index_reg == '0)
                                    begin
                                        class_next = id_class;
                                    end
                                    emit                 = 1'b1;
                                    emit_res.event_class = (index_reg == '0) ?
                                                           id_class : class_reg;
                                    emit_res.word_offset = index_reg;
                                    emit_res.first_word  = (index_reg == '0);
                                    emit_res.last_word   = (items_reg == 11'd1);
                                    index_next = index_reg + 10'd1;
                                    items_next = items_reg - 11'd1;
                                    if (items_reg == 11'd1)
                                    begin
                                        phase_next = (left_dec == '0) ? PH_DONE : PH_HDR;
                                    end
                                end
                            end
                        endcase
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            time_reg      <= '0;
            len_lo_reg    <= '0;
            left_reg      <= '0;
            items_reg     <= '0;
            delta_reg     <= '0;
            class_reg     <= trp_pkg::CLASS_NONE;
            index_reg     <= '0;
            cpu_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg  <= phase_next;
                time_reg   <= time_next;
                len_lo_reg <= len_lo_next;
                left_reg   <= left_next;
                items_reg  <= items_next;
                delta_reg  <= delta_next;
                class_reg  <= class_next;
                index_reg  <= index_next;
                cpu_reg    <= cpu_next;
            end
            if (in_ready)
            begin
                res_valid_reg <= take && emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            res_reg <= emit_res;
        end
    end
endmodule

// ===== hdl/trace_ring_page_parser.sv =====
// ----------------------------------------------------------------------------
// trace_ring_page_parser
// Decodes trace pages word by word into tagged payload words.
// ----------------------------------------------------------------------------
//  channel   | dir | carries
//  page_in   | in  | page_word, page_start, cpu_number
//  result    | out | data_word .. status, one word per payload word or error
//  cfg_*     | in  | id registers 0..3, write only
//
// One word a cycle sustained while results are taken; the core keeps a 64-bit event time.
// Input words pass a 4-entry queue, results a registered output stage:
// a word is held in the queue memory and its result in the output register.
// Reset clears all parse state; no clearing pass is needed.
// Either side may stall freely; the queue absorbs short output stalls.
module trace_ring_page_parser #(
    parameter int unsigned PAGE_BYTES = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    trp_in_if.sink                          page_in,
    trp_out_if.source                       result,
    input  logic                            cfg_we,
    input  logic [trp_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [trp_pkg::REG_W-1:0]       cfg_data
);
    logic [trp_pkg::REG_W-1:0] id_reg [trp_pkg::NUM_REGS];
    trp_pkg::item_t   in_item, q_item;
    logic             q_valid, q_ready;
    trp_pkg::result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < int'(trp_pkg::NUM_REGS); i++)
            begin
                id_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            id_reg[cfg_index] <= cfg_data;
        end
    end

    assign in_item.word  = page_in.page_word;
    assign in_item.start = page_in.page_start;
    assign in_item.cpu   = page_in.cpu_number;

    trp_queue #(.DEPTH(4)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (page_in.valid),
        .in_ready  (page_in.ready),
        .in_item   (in_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    trp_core #(.PAGE_BYTES(PAGE_BYTES)) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .id_entry  (id_reg[trp_pkg::REG_ENTRY]),
        .id_exit   (id_reg[trp_pkg::REG_EXIT]),
        .id_switch (id_reg[trp_pkg::REG_SWITCH]),
        .id_wakeup (id_reg[trp_pkg::REG_WAKEUP]),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .res       (res)
    );

    assign result.data_word   = res.data_word;
    assign result.event_class = res.event_class;
    assign result.event_time  = res.event_time;
    assign result.cpu_tag     = res.cpu_tag;
    assign result.word_offset = res.word_offset;
    assign result.first_word  = res.first_word;
    assign result.last_word   = res.last_word;
    assign result.status      = res.status;
endmodule

// ===== hdl/trp_checker.sv =====
// ----------------------------------------------------------------------------
// trp_checker
// Port-level checks on the trace page parser.
// ----------------------------------------------------------------------------
`include "trace_ring_page_parser_assert.svh"
module trp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  event_class,
    input logic [1:0]  status,
    input logic        first_word,
    input logic        last_word,
    input logic [9:0]  word_offset
);
    `TRP_ASSERT_IMP(a_err_fields, out_valid && status != trp_pkg::ST_OK,
        event_class == trp_pkg::CLASS_NONE && !first_word && !last_word && word_offset == 10'd0)
    `TRP_ASSERT_IMP(a_ok_class, out_valid && status == trp_pkg::ST_OK,
        event_class != trp_pkg::CLASS_NONE)
    `TRP_ASSERT_IMP(a_first_off, out_valid && first_word, word_offset == 10'd0)
    `TRP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(status))
endmodule

bind trace_ring_page_parser trp_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .event_class (result.event_class),
    .status      (result.status),
    .first_word  (result.first_word),
    .last_word   (result.last_word),
    .word_offset (result.word_offset)
);

// ===== verif/trace_ring_page_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trace_ring_page_parser_tb
// Self-checking bench for the trace page parser. A short table of hand-built
// pages is followed by randomly built pages under several id settings. Every
// accepted word goes through a behavioural decoder, and each result word is
// checked field by field against the oldest predicted one. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module trace_ring_page_parser_tb;

    localparam int unsigned PAGE_BYTES = 4096;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned RANDOM_WORDS = 750;

    localparam logic [4:0] TYPE_ERR = 5'd31;

    typedef enum logic [3:0] {
        PH_WAIT, PH_TS_HI, PH_LEN_LO, PH_LEN_HI, PH_HDR, PH_LEN0, PH_PAD_LEN,
        PH_PAD_SKIP, PH_EXT, PH_PAYLOAD, PH_DONE, PH_DISCARD
    } phase_t;

    typedef struct {
        logic [31:0] word;
        logic        start;
        logic [9:0]  cpu;
        bit          has_status;
        logic [1:0]  status;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [trp_pkg::REG_IDX_W-1:0] cfg_index;
    logic [trp_pkg::REG_W-1:0] cfg_data;

    trp_in_if  page_in ();
    trp_out_if result ();

    trace_ring_page_parser #(.PAGE_BYTES(PAGE_BYTES)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .page_in   (page_in),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // decoder state
    logic [15:0] id_reg [trp_pkg::NUM_REGS];
    phase_t      phase;
    logic [63:0] run_time;
    int unsigned region_left;
    int unsigned words_left;
    logic [26:0] held_delta;
    logic [2:0]  cur_class;
    logic [9:0]  pay_index;
    logic [9:0]  cur_cpu;

    trp_pkg::result_t expected_words [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned sent;
    int unsigned errors_seen;
    int unsigned cycles = 0;
    int unsigned pages;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles,
                     expected_words.size());
            $display("trace_ring_page_parser regression: fail");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 94)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic void decoder_reset();
        phase = PH_WAIT;
        run_time = '0;
        region_left = 0;
        words_left = 0;
        held_delta = '0;
        cur_class = trp_pkg::CLASS_NONE;
        pay_index = '0;
        cur_cpu = '0;
        for (int i = 0; i < trp_pkg::NUM_REGS; i++)
            id_reg[i] = '0;
    endfunction

    function automatic trp_pkg::result_t make_word(logic [31:0] w, logic [2:0] cls,
                                                   logic [9:0] off, logic first,
                                                   logic last, logic [1:0] st);
        trp_pkg::result_t r;
        r.data_word = w;
        r.event_class = cls;
        r.event_time = run_time;
        r.cpu_tag = cur_cpu;
        r.word_offset = off;
        r.first_word = first;
        r.last_word = last;
        r.status = st;
        return r;
    endfunction

    function automatic bit reject(logic [31:0] w, logic [1:0] st,
                                  output trp_pkg::result_t r);
        r = make_word(w, trp_pkg::CLASS_NONE, '0, 1'b0, 1'b0, st);
        phase = PH_DISCARD;
        return 1'b1;
    endfunction

    function automatic void next_header();
        phase = (region_left == 0) ? PH_DONE : PH_HDR;
    endfunction

    // remaining body words of a self-counting length word, -1 if it is below 4 or overruns
    function automatic int body_fit(logic [31:0] w);
        longint unsigned nw;
        if (w < 4)
            return -1;
        nw = (longint'(w) - 4 + 3) >> 2;
        if (nw * 4 > region_left)
            return -1;
        return int'(nw);
    endfunction

    function automatic bit decode_word(logic [31:0] w, logic start, logic [9:0] cpu,
                                       output trp_pkg::result_t r);
        logic [4:0]  ty;
        logic [26:0] dl;
        logic [15:0] id;
        int n;
        bit first;
        r = '0;
        if (start)
        begin
            cur_cpu = cpu;
            run_time = {32'h0, w};
            region_left = 0;
            words_left = 0;
            held_delta = '0;
            pay_index = '0;
            cur_class = trp_pkg::CLASS_NONE;
            phase = PH_TS_HI;
            return 1'b0;
        end
        case (phase)
            PH_TS_HI:
            begin
                run_time[63:32] = w;
                phase = PH_LEN_LO;
                return 1'b0;
            end
            PH_LEN_LO:
            begin
                region_left = w;
                phase = PH_LEN_HI;
                return 1'b0;
            end
            PH_LEN_HI:
            begin
                if (w != 0 || region_left > PAGE_BYTES - 16)
                begin
                    region_left = 0;
                    return reject(w, trp_pkg::ST_OVERRUN, r);
                end
                next_header();
                return 1'b0;
            end
            PH_HDR, PH_LEN0, PH_PAD_LEN, PH_PAD_SKIP, PH_EXT, PH_PAYLOAD: ;
            default: return 1'b0;
        endcase

        if (region_left < 4)
            return reject(w, trp_pkg::ST_OVERRUN, r);
        region_left -= 4;

        case (phase)
            PH_HDR:
            begin
                ty = w[4:0];
                dl = w[31:5];
                if (ty == trp_pkg::TYPE_LEN0)
                begin
                    held_delta = dl;
                    phase = PH_LEN0;
                end
                else if (ty <= trp_pkg::TYPE_MAXDATA)
                begin
                    if (ty * 4 > region_left)
                        return reject(w, trp_pkg::ST_OVERRUN, r);
                    run_time += dl;
                    words_left = 32'(ty);
                    pay_index = '0;
                    phase = PH_PAYLOAD;
                end
                else if (ty == trp_pkg::TYPE_PAD)
                begin
                    if (dl == 0)
                        phase = PH_DONE;
                    else
                    begin
                        held_delta = dl;
                        phase = PH_PAD_LEN;
                    end
                end
                else if (ty == trp_pkg::TYPE_EXT)
                begin
                    held_delta = dl;
                    phase = PH_EXT;
                end
                else
                    return reject(w, trp_pkg::ST_BAD_TYPE, r);
                return 1'b0;
            end
            PH_LEN0, PH_PAD_LEN:
            begin
                n = body_fit(w);
                if (n < 0)
                    return reject(w, trp_pkg::ST_OVERRUN, r);
                run_time += held_delta;
                words_left = n;
                if (phase == PH_LEN0)
                    pay_index = '0;
                if (n == 0)
                    next_header();
                else
                    phase = (phase == PH_LEN0) ? PH_PAYLOAD : PH_PAD_SKIP;
                return 1'b0;
            end
            PH_PAD_SKIP:
            begin
                words_left--;
                if (words_left == 0)
                    next_header();
                return 1'b0;
            end
            PH_EXT:
            begin
                run_time += ({32'h0, w} << trp_pkg::DELTA_SHIFT) + held_delta;
                next_header();
                return 1'b0;
            end
            default:
            begin
                first = (pay_index == 0);
                if (first)
                begin
                    id = w[15:0];
                    if (id == id_reg[trp_pkg::REG_ENTRY])
                        cur_class = trp_pkg::CLASS_ENTRY;
                    else if (id == id_reg[trp_pkg::REG_EXIT])
                        cur_class = trp_pkg::CLASS_EXIT;
                    else if (id == id_reg[trp_pkg::REG_SWITCH])
                        cur_class = trp_pkg::CLASS_SWITCH;
                    else if (id == id_reg[trp_pkg::REG_WAKEUP])
                        cur_class = trp_pkg::CLASS_WAKEUP;
                    else
                        return reject(w, trp_pkg::ST_BAD_ID, r);
                end
                r = make_word(w, cur_class, pay_index, first, words_left == 1,
                              trp_pkg::ST_OK);
                pay_index++;
                words_left--;
                if (words_left == 0)
                    next_header();
                return 1'b1;
            end
        endcase
    endfunction

    // one page word through the handshake; prediction on acceptance
    task automatic send_word(logic [31:0] w, logic start, logic [9:0] cpu,
                             bit has_status = 1'b0, logic [1:0] st = trp_pkg::ST_OK);
        int unsigned gap;
        trp_pkg::result_t r;
        bit got;
        gap = pick_gap();
        if (gap > 0)
        begin
            page_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        page_in.valid <= 1'b1;
        page_in.page_word <= w;
        page_in.page_start <= start;
        page_in.cpu_number <= cpu;
        do
            @(posedge clk);
        while (!page_in.ready);
        sent++;
        got = decode_word(w, start, cpu, r);
        if (has_status && !(got && r.status == st))
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row %0d: decoder disagrees with typed status %0d", sent, st);
        end
        if (got)
            expected_words.push_back(r);
    endtask

    task automatic wait_idle();
        page_in.valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        id_reg[idx] = val;
    endtask

    task automatic write_ids(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] d);
        write_reg(trp_pkg::REG_ENTRY, a);
        write_reg(trp_pkg::REG_EXIT, b);
        write_reg(trp_pkg::REG_SWITCH, c);
        write_reg(trp_pkg::REG_WAKEUP, d);
    endtask

    function automatic logic [31:0] id_word();
        logic [31:0] w;
        w = $urandom();
        if ($urandom_range(0, 9) < 8)
            w[15:0] = id_reg[$urandom_range(0, trp_pkg::NUM_REGS - 1)];
        return w;
    endfunction

    function automatic logic [26:0] rand_delta();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return 27'($urandom_range(0, 5000));
        endcase
    endfunction

    task automatic send_body(int unsigned n, logic [9:0] cpu);
        for (int i = 0; i < n; i++)
            send_word(i == 0 ? id_word() : $urandom(), 1'b0, cpu);
    endtask

    // a mostly well-formed page with random content; now and then broken
    task automatic random_page();
        logic [9:0]  cpu;
        logic [31:0] len;
        logic [31:0] len_hi;
        int unsigned rem;
        int unsigned t;
        int unsigned b;
        int unsigned k;
        bit stop;
        cpu = 10'($urandom());
        len_hi = '0;
        k = $urandom_range(0, 19);
        if (k == 0)
            len = '0;
        else if (k == 1)
            len = PAGE_BYTES - 16;
        else if (k == 2)
            len = $urandom_range(PAGE_BYTES - 15, 9000);
        else if (k == 3)
        begin
            len = 4 * $urandom_range(1, 20);
            len_hi = $urandom() | 32'h1;
        end
        else
            len = 4 * $urandom_range(2, 48);
        send_word($urandom(), 1'b1, cpu);
        send_word($urandom(), 1'b0, cpu);
        send_word(len, 1'b0, cpu);
        send_word(len_hi, 1'b0, cpu);
        rem = (len > PAGE_BYTES) ? 0 : len;
        stop = 1'b0;
        while (rem >= 8 && !stop)
        begin
            k = $urandom_range(0, 19);
            if (k < 11)
            begin
                t = $urandom_range(1, ((rem - 4) / 4 > 28) ? 28 : (rem - 4) / 4);
                send_word({rand_delta(), 5'(t)}, 1'b0, cpu);
                send_body(t, cpu);
                rem -= 4 + 4 * t;
            end
            else if (k < 14)
            begin
                // odd byte counts round up; body still fits the region
                b = 4 + $urandom_range(0, (rem - 8 > 40) ? 40 : rem - 8);
                t = (b - 4 + 3) / 4;
                send_word({rand_delta(), trp_pkg::TYPE_LEN0}, 1'b0, cpu);
                send_word(b, 1'b0, cpu);
                send_body(t, cpu);
                rem -= 8 + 4 * t;
            end
            else if (k == 14)
            begin
                b = 4 + $urandom_range(0, (rem - 8 > 24) ? 24 : rem - 8);
                t = (b - 4 + 3) / 4;
                send_word({27'($urandom_range(1, 1000)), trp_pkg::TYPE_PAD}, 1'b0, cpu);
                send_word(b, 1'b0, cpu);
                for (int i = 0; i < t; i++)
                    send_word($urandom(), 1'b0, cpu);
                rem -= 8 + 4 * t;
            end
            else if (k < 17)
            begin
                send_word({rand_delta(), trp_pkg::TYPE_EXT}, 1'b0, cpu);
                send_word($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 9),
                          1'b0, cpu);
                rem -= 8;
            end
            else if (k == 17)
            begin
                send_word({27'h0, trp_pkg::TYPE_PAD}, 1'b0, cpu);
                stop = 1'b1;
            end
            else if (k == 18)
            begin
                send_word({rand_delta(), TYPE_ERR}, 1'b0, cpu);
                stop = 1'b1;
            end
            else
            begin
                // noise: raw words, may overrun or hit any header type
                for (int i = 0; i < $urandom_range(1, 4); i++)
                    send_word($urandom(), 1'b0, cpu);
                stop = 1'b1;
            end
        end
        // trailing words are ignored, or overrun a region that is nearly spent
        for (int i = 0; i < $urandom_range(0, 2); i++)
            send_word($urandom(), 1'b0, cpu);
        pages++;
    endtask

    // result side: random stalls, in-order comparison
    always @(posedge clk)
    begin
        trp_pkg::result_t exp_w;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h status %0d", result.data_word,
                             result.status);
            end
            else
            begin
                exp_w = expected_words.pop_front();
                checked++;
                if (exp_w.status != trp_pkg::ST_OK)
                    errors_seen++;
                if (result.data_word !== exp_w.data_word
                    || result.event_class !== exp_w.event_class
                    || result.event_time !== exp_w.event_time
                    || result.cpu_tag !== exp_w.cpu_tag
                    || result.word_offset !== exp_w.word_offset
                    || result.first_word !== exp_w.first_word
                    || result.last_word !== exp_w.last_word
                    || result.status !== exp_w.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch #%0d exp w=%h c=%0d t=%h cpu=%0d off=%0d f=%b l=%b",
                                  " s=%0d / got w=%h c=%0d t=%h cpu=%0d off=%0d f=%b l=%b s=%0d"},
                                 checked, exp_w.data_word, exp_w.event_class,
                                 exp_w.event_time, exp_w.cpu_tag, exp_w.word_offset,
                                 exp_w.first_word, exp_w.last_word, exp_w.status,
                                 result.data_word, result.event_class, result.event_time,
                                 result.cpu_tag, result.word_offset, result.first_word,
                                 result.last_word, result.status);
                end
            end
        end
        result.ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 20) == 0);
    end

    initial
    begin
        stim_row_t dir_rows [$];
        mismatches = 0;
        checked = 0;
        sent = 0;
        errors_seen = 0;
        pages = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        page_in.valid = 1'b0;
        page_in.page_word = '0;
        page_in.page_start = 1'b0;
        page_in.cpu_number = '0;
        decoder_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        write_ids(16'h0101, 16'h0202, 16'h0303, 16'h0404);

        dir_rows = '{
            '{32'hDEAD_BEEF, 1'b0, 10'd5,   1'b0, trp_pkg::ST_OK},    // before any page
            '{32'hFFFF_FFFF, 1'b1, 10'd1023, 1'b0, trp_pkg::ST_OK},
            '{32'hFFFF_FFFF, 1'b0, 10'd0,   1'b0, trp_pkg::ST_OK},
            '{32'd64,        1'b0, 10'd0,   1'b0, trp_pkg::ST_OK},
            '{32'd0,         1'b0, 10'd0,   1'b0, trp_pkg::ST_OK},
            '{{27'h7FF_FFFF, 5'd2}, 1'b0, 10'd0, 1'b0, trp_pkg::ST_OK}, // delta wraps time
            '{32'h0000_0101, 1'b0, 10'd0,   1'b0, trp_pkg::ST_OK},
            '{32'hFFFF_FFFF, 1'b0, 10'd0,   1'b0, trp_pkg::ST_OK},
            '{{27'd1, trp_pkg::TYPE_EXT}, 1'b0, 10'd0, 1'b0, trp_pkg::ST_OK},
            '{32'd5,         1'b0, 10'd0,   1'b0, trp_pkg::ST_OK},
            '{{27'd3, trp_pkg::TYPE_LEN0}, 1'b0, 10'd0, 1'b0, trp_pkg::ST_OK},
            '{32'd4,         1'b0, 10'd0,   1'b0, trp_pkg::ST_OK},    // empty event
            '{{27'd0, trp_pkg::TYPE_LEN0}, 1'b0, 10'd0, 1'b0, trp_pkg::ST_OK},
            '{32'd9,         1'b0, 10'd0,   1'b0, trp_pkg::ST_OK},    // odd length
            '{32'hABCD_0404, 1'b0, 10'd0,   1'b0, trp_pkg::ST_OK},
            '{32'h0000_0000, 1'b0, 10'd0,   1'b0, trp_pkg::ST_OK},
            '{{27'd2, trp_pkg::TYPE_PAD}, 1'b0, 10'd0, 1'b0, trp_pkg::ST_OK},
            '{32'd8,         1'b0, 10'd0,   1'b0, trp_pkg::ST_OK},
            '{32'h1234_5678, 1'b0, 10'd0,   1'b0, trp_pkg::ST_OK},
            '{{27'd0, 5'd1}, 1'b0, 10'd0,   1'b0, trp_pkg::ST_OK},
            '{32'h0000_0303, 1'b0, 10'd0,   1'b0, trp_pkg::ST_OK},    // ends region
            '{32'h5555_5555, 1'b0, 10'd0,   1'b0, trp_pkg::ST_OK},    // after data end
            '{32'd0,         1'b1, 10'd0,   1'b0, trp_pkg::ST_OK},
            '{32'd0,         1'b0, 10'd0,   1'b0, trp_pkg::ST_OK},
            '{PAGE_BYTES - 15, 1'b0, 10'd0, 1'b0, trp_pkg::ST_OK},
            '{32'd0,         1'b0, 10'd0,   1'b1, trp_pkg::ST_OVERRUN},
            '{32'd0,         1'b1, 10'd7,   1'b0, trp_pkg::ST_OK},
            '{32'd0,         1'b0, 10'd7,   1'b0, trp_pkg::ST_OK},
            '{PAGE_BYTES - 16, 1'b0, 10'd7, 1'b0, trp_pkg::ST_OK},
            '{32'd0,         1'b0, 10'd7,   1'b0, trp_pkg::ST_OK},
            '{{27'd9, TYPE_ERR}, 1'b0, 10'd7, 1'b1, trp_pkg::ST_BAD_TYPE}
        };
        foreach (dir_rows[i])
            send_word(dir_rows[i].word, dir_rows[i].start, dir_rows[i].cpu,
                      dir_rows[i].has_status, dir_rows[i].status);
        wait_idle();

        // phases: random ids, extremes with a duplicate, then random ids mixed with extremes
        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 0)
                write_ids(16'($urandom()), 16'($urandom()), 16'($urandom()),
                          16'($urandom()));
            else if (ph == 1)
                write_ids(16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000);
            else
                write_ids(16'($urandom()), 16'($urandom()), 16'hFFFF, 16'h0000);
            while (sent < 31 + (ph + 1) * RANDOM_WORDS / 3)
                random_page();
            wait_idle();
        end

        $display("%0d words sent over %0d random pages, %0d result words checked, %0d errors",
                 sent, pages, checked, errors_seen);
        $display("id settings: directed, random, extremes with duplicates, mixed");
        if (mismatches == 0 && expected_words.size() == 0)
            $display("trace_ring_page_parser regression: pass");
        else
        begin
            $display("%0d mismatches, %0d words still expected", mismatches,
                     expected_words.size());
            $display("trace_ring_page_parser regression: fail");
        end
        $finish;
    end

endmodule
